>>> design/hnfr_pkg.sv
// ============================================================================
// hnfr_pkg
// Shared types, codes and constants for the NRZI HDLC frame receiver.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package hnfr_pkg;

    // Input opcodes
    localparam logic OP_SYMBOL = 1'b0;
    localparam logic OP_READ   = 1'b1;

    // Result kinds
    localparam logic RES_ACCEPT = 1'b0;
    localparam logic RES_READ   = 1'b1;

    // Field widths fixed by the interface
    localparam int LEN_W     = 9;
    localparam int IDX_W     = 9;
    localparam int FLAG_W    = 32;
    localparam int LONGEST_W = 10;

    // Framing and check constants
    localparam logic [7:0]  FLAG_PATTERN = 8'h7E;
    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY     = 16'h8408;
    localparam logic [15:0] CRC_XOROUT   = 16'hFFFF;
    localparam logic [2:0]  ABORT_RUN    = 3'd7;
    localparam logic [2:0]  STUFF_RUN    = 3'd5;
    localparam int          MIN_FRAME    = 4;

    // Command queue between decoder and buffer side
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        CMD_WRITE  = 2'd0,
        CMD_ACCEPT = 2'd1,
        CMD_READ   = 2'd2
    } t_cmd_kind;

    // One queued command; the buffer address travels alongside
    typedef struct packed {
        t_cmd_kind              kind;
        logic                   bank;
        logic [7:0]             data;
        logic                   zero;
        logic [LEN_W-1:0]       frame_length;
        logic [FLAG_W-1:0]      flag_total;
        logic [LONGEST_W-1:0]   longest_fill;
    } t_cmd;

    // CRC-16/X.25 reflected update over one byte
    function automatic logic [15:0] crc_fold(input logic [15:0] c, input logic [7:0] v);
        logic [15:0] x;
        x = c ^ {8'h00, v};
        for (int k = 0; k < 8; k++) begin
            x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
        end
        return x;
    endfunction

endpackage

`default_nettype wire

>>> design/hnfr_front.sv
// ============================================================================
// hnfr_front
// Line decoder: NRZI decode, flag hunt, bit destuffing, byte packing, running
// CRC and frame accept. Emits buffer writes, accept and read commands.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module hnfr_front
    import hnfr_pkg::*;
#(
    parameter int FRAME_BYTES = 512,
    parameter int AW          = 9,
    parameter int CW          = 10
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic              i_opcode,
    input  wire logic              i_line_symbol,
    input  wire logic [IDX_W-1:0]  i_read_index,
    input  wire logic              i_q_full,
    output logic                   o_push,
    output t_cmd                   o_cmd,
    output logic [AW-1:0]          o_addr
);

    localparam int HW = (CW > LEN_W) ? CW : LEN_W;
    localparam int LW = (CW > LONGEST_W) ? CW : LONGEST_W;
    localparam int IW = (AW > IDX_W) ? AW : IDX_W;

    logic          r_prev_level, n_prev_level;
    logic [7:0]    r_window,     n_window;
    logic          r_inside,     n_inside;
    logic [2:0]    r_ones,       n_ones;
    logic [2:0]    r_bit_pos,    n_bit_pos;
    logic [7:0]    r_partial,    n_partial;
    logic [CW-1:0] r_fill,       n_fill;
    logic          r_bank,       n_bank;
    logic [CW-1:0] r_held,       n_held;
    logic [15:0]   r_crc,        n_crc;
    logic [7:0]    r_recent0,    n_recent0;
    logic [7:0]    r_recent1,    n_recent1;
    logic [31:0]   r_flag_cnt,   n_flag_cnt;
    logic [CW-1:0] r_longest,    n_longest;

    logic accept;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;

    // Next state and command generation
    always_comb begin
        logic          dbit;
        logic [7:0]    win;
        logic          tb_en;
        logic          tb_val;
        logic [7:0]    pb;
        logic [CW-1:0] new_fill;
        logic [CW-1:0] acc_len;
        logic [HW-1:0] held_x;
        logic [HW-1:0] acc_x;
        logic [HW-1:0] idx_x;
        logic [LW-1:0] long_x;
        logic [IW-1:0] idx_w;

        n_prev_level = r_prev_level;
        n_window     = r_window;
        n_inside     = r_inside;
        n_ones       = r_ones;
        n_bit_pos    = r_bit_pos;
        n_partial    = r_partial;
        n_fill       = r_fill;
        n_bank       = r_bank;
        n_held       = r_held;
        n_crc        = r_crc;
        n_recent0    = r_recent0;
        n_recent1    = r_recent1;
        n_flag_cnt   = r_flag_cnt;
        n_longest    = r_longest;

        o_push = 1'b0;
        o_cmd  = '0;
        o_addr = '0;

        dbit     = (i_line_symbol == r_prev_level);
        win      = {r_window[6:0], dbit};
        tb_en    = 1'b0;
        tb_val   = dbit;
        pb       = r_partial | (8'(tb_val) << r_bit_pos);
        new_fill = r_fill;
        acc_len  = r_fill - CW'(2);
        held_x   = HW'(r_held);
        acc_x    = HW'(acc_len);
        idx_x    = HW'(i_read_index);
        long_x   = LW'(r_longest);
        idx_w    = IW'(i_read_index);

        if (accept) begin
            if (i_opcode == OP_READ) begin
                // Read of the held bank
                o_push             = 1'b1;
                o_cmd.kind         = CMD_READ;
                o_cmd.bank         = ~r_bank;
                o_cmd.zero         = !(idx_x < held_x);
                o_cmd.frame_length = held_x[LEN_W-1:0];
                o_cmd.flag_total   = r_flag_cnt;
                o_cmd.longest_fill = long_x[LONGEST_W-1:0];
                o_addr             = idx_w[AW-1:0];
            end else begin
                n_prev_level = i_line_symbol;
                n_window     = win;
                if (win == FLAG_PATTERN) begin
                    // Flag: close any open frame, open a new one
                    n_flag_cnt = r_flag_cnt + 32'd1;
                    if (r_inside && (r_fill >= CW'(MIN_FRAME))
                        && ((r_crc ^ CRC_XOROUT) == {r_recent0, r_recent1})) begin
                        n_held             = acc_len;
                        n_bank             = ~r_bank;
                        o_push             = 1'b1;
                        o_cmd.kind         = CMD_ACCEPT;
                        o_cmd.bank         = r_bank;
                        o_cmd.zero         = 1'b1;
                        o_cmd.frame_length = acc_x[LEN_W-1:0];
                        o_cmd.flag_total   = r_flag_cnt + 32'd1;
                        o_cmd.longest_fill = long_x[LONGEST_W-1:0];
                    end
                    n_inside  = 1'b1;
                    n_fill    = '0;
                    n_bit_pos = '0;
                    n_partial = '0;
                    n_ones    = '0;
                    n_crc     = CRC_INIT;
                    n_recent0 = '0;
                    n_recent1 = '0;
                end else if (r_inside) begin
                    if (dbit) begin
                        // Seven ones abort the frame
                        if (r_ones + 3'd1 >= ABORT_RUN) begin
                            n_inside = 1'b0;
                            n_ones   = '0;
                        end else begin
                            n_ones = r_ones + 3'd1;
                            tb_en  = 1'b1;
                        end
                    end else begin
                        // Zero after five ones is stuffing
                        n_ones = '0;
                        tb_en  = (r_ones != STUFF_RUN);
                    end
                end
            end
        end

        // Bit packing, LSB first
        if (tb_en) begin
            if (r_bit_pos == 3'd7) begin
                if (r_fill < CW'(FRAME_BYTES)) begin
                    o_push     = 1'b1;
                    o_cmd.kind = CMD_WRITE;
                    o_cmd.bank = r_bank;
                    o_cmd.data = pb;
                    o_addr     = r_fill[AW-1:0];
                    if (r_fill >= CW'(2)) begin
                        n_crc = crc_fold(r_crc, r_recent1);
                    end
                    n_recent1 = r_recent0;
                    n_recent0 = pb;
                    new_fill  = r_fill + CW'(1);
                    n_fill    = new_fill;
                end
                if (new_fill > r_longest) begin
                    n_longest = new_fill;
                end
                n_partial = '0;
                n_bit_pos = '0;
            end else begin
                n_partial = pb;
                n_bit_pos = r_bit_pos + 3'd1;
            end
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_level <= 1'b1;
            r_window     <= '0;
            r_inside     <= 1'b0;
            r_ones       <= '0;
            r_bit_pos    <= '0;
            r_partial    <= '0;
            r_fill       <= '0;
            r_bank       <= 1'b0;
            r_held       <= '0;
            r_crc        <= CRC_INIT;
            r_recent0    <= '0;
            r_recent1    <= '0;
            r_flag_cnt   <= '0;
            r_longest    <= '0;
        end else begin
            r_prev_level <= n_prev_level;
            r_window     <= n_window;
            r_inside     <= n_inside;
            r_ones       <= n_ones;
            r_bit_pos    <= n_bit_pos;
            r_partial    <= n_partial;
            r_fill       <= n_fill;
            r_bank       <= n_bank;
            r_held       <= n_held;
            r_crc        <= n_crc;
            r_recent0    <= n_recent0;
            r_recent1    <= n_recent1;
            r_flag_cnt   <= n_flag_cnt;
            r_longest    <= n_longest;
        end
    end

endmodule

`default_nettype wire

>>> design/hnfr_queue.sv
// ============================================================================
// hnfr_queue
// Short command FIFO between the line decoder and the buffer side.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module hnfr_queue
    import hnfr_pkg::*;
#(
    parameter int AW = 9
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire t_cmd          i_cmd,
    input  wire logic [AW-1:0] i_addr,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_valid,
    output t_cmd               o_cmd,
    output logic [AW-1:0]      o_addr
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    t_cmd          r_cmd  [QUEUE_DEPTH];
    logic [AW-1:0] r_addr [QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [NW-1:0] r_count,  n_count;

    assign o_full  = (r_count == NW'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_cmd[r_rd_ptr];
    assign o_addr  = r_addr[r_rd_ptr];

    // Pointer and occupancy update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = r_wr_ptr + PW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = r_rd_ptr + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + NW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - NW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_cmd[r_wr_ptr]  <= i_cmd;
            r_addr[r_wr_ptr] <= i_addr;
        end
    end

endmodule

`default_nettype wire

>>> design/hnfr_back.sv
// ============================================================================
// hnfr_back
// Buffer side: two-bank byte store, read replies and the result register.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module hnfr_back
    import hnfr_pkg::*;
#(
    parameter int AW = 9
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_q_valid,
    input  wire t_cmd                  i_cmd,
    input  wire logic [AW-1:0]         i_addr,
    output logic                       o_pop,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic                       o_result_kind,
    output logic [LEN_W-1:0]           o_frame_length,
    output logic [7:0]                 o_read_byte,
    output logic [FLAG_W-1:0]          o_flag_total,
    output logic [LONGEST_W-1:0]       o_longest_fill
);

    localparam int MEM_DEPTH = 2 ** (AW + 1);

    logic [7:0]           r_mem [MEM_DEPTH];
    logic                 r_out_valid, n_out_valid;
    logic                 r_kind;
    logic [LEN_W-1:0]     r_len;
    logic [FLAG_W-1:0]    r_flag;
    logic [LONGEST_W-1:0] r_longest;
    logic                 r_zero;
    logic [7:0]           r_rd_data;

    logic          is_res;
    logic          out_free;
    logic          load;
    logic [AW:0]   mem_addr;

    assign is_res   = (i_cmd.kind != CMD_WRITE);
    assign out_free = !r_out_valid || i_out_ready;
    assign o_pop    = i_q_valid && (!is_res || out_free);
    assign load     = o_pop && is_res;
    assign mem_addr = {i_cmd.bank, i_addr};

    // Result register occupancy
    always_comb begin
        n_out_valid = r_out_valid;
        if (out_free) begin
            n_out_valid = load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind    <= (i_cmd.kind == CMD_READ) ? RES_READ : RES_ACCEPT;
            r_len     <= i_cmd.frame_length;
            r_flag    <= i_cmd.flag_total;
            r_longest <= i_cmd.longest_fill;
            r_zero    <= i_cmd.zero || (i_cmd.kind != CMD_READ);
        end
    end

    // Byte store: one write or one read per beat
    always_ff @(posedge i_clk) begin
        if (o_pop && (i_cmd.kind == CMD_WRITE)) begin
            r_mem[mem_addr] <= i_cmd.data;
        end
        if (o_pop && (i_cmd.kind == CMD_READ)) begin
            r_rd_data <= r_mem[mem_addr];
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_kind  = r_kind;
    assign o_frame_length = r_len;
    assign o_read_byte    = r_zero ? 8'h00 : r_rd_data;
    assign o_flag_total   = r_flag;
    assign o_longest_fill = r_longest;

endmodule

`default_nettype wire

>>> design/hdlc_nrzi_frame_receiver.sv
// ============================================================================
// hdlc_nrzi_frame_receiver
// NRZI line decoder and HDLC frame receiver with CRC-16/X.25 check and a
// double-buffered byte store that holds the last accepted frame for reads.
// ============================================================================
//
//  channel | handshake                  | payload
//  --------+----------------------------+----------------------------------------
//  in      | i_in_valid / o_in_ready    | i_opcode, i_line_symbol, i_read_index
//  out     | o_out_valid / i_out_ready  | o_result_kind, o_frame_length,
//          |                            | o_read_byte, o_flag_total, o_longest_fill
//
//  One beat per clock while the command queue is not full. A result is
//  registered first as a decoder command in the command queue, then by the
//  store read into the result register.
//  The four-entry command queue lets the decoder keep taking beats while a
//  result waits; o_in_ready drops only when the queue is full.
//  Reset is synchronous, active low; the byte store is not cleared and
//  needs no clearing pass, since reads never reach unwritten bytes.
//
`timescale 1ns / 1ps
`default_nettype none

module hdlc_nrzi_frame_receiver
    import hnfr_pkg::*;
#(
    parameter int FRAME_BYTES = 512
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic                  i_opcode,
    input  wire logic                  i_line_symbol,
    input  wire logic [IDX_W-1:0]      i_read_index,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic                       o_result_kind,
    output logic [LEN_W-1:0]           o_frame_length,
    output logic [7:0]                 o_read_byte,
    output logic [FLAG_W-1:0]          o_flag_total,
    output logic [LONGEST_W-1:0]       o_longest_fill
);

    localparam int AW = $clog2(FRAME_BYTES);
    localparam int CW = $clog2(FRAME_BYTES + 1);

    logic          q_full;
    logic          push;
    t_cmd          push_cmd;
    logic [AW-1:0] push_addr;
    logic          pop;
    logic          head_valid;
    t_cmd          head_cmd;
    logic [AW-1:0] head_addr;

    // Decoder
    hnfr_front #(
        .FRAME_BYTES (FRAME_BYTES),
        .AW          (AW),
        .CW          (CW)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_opcode      (i_opcode),
        .i_line_symbol (i_line_symbol),
        .i_read_index  (i_read_index),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_cmd         (push_cmd),
        .o_addr        (push_addr)
    );

    // Command queue
    hnfr_queue #(
        .AW (AW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_addr  (push_addr),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_cmd   (head_cmd),
        .o_addr  (head_addr)
    );

    // Byte store and results
    hnfr_back #(
        .AW (AW)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (head_valid),
        .i_cmd          (head_cmd),
        .i_addr         (head_addr),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_result_kind  (o_result_kind),
        .o_frame_length (o_frame_length),
        .o_read_byte    (o_read_byte),
        .o_flag_total   (o_flag_total),
        .o_longest_fill (o_longest_fill)
    );

endmodule

`default_nettype wire

>>> tb/hdlc_nrzi_frame_receiver_test.sv
`timescale 1ns / 1ps
// ============================================================================
// hdlc_nrzi_frame_receiver_test
// Self-checking bench for the NRZI HDLC frame receiver. Frames are built
// with a proper FCS, bit-stuffed and NRZI-encoded into line symbols, then
// mixed with reads of the held frame, broken frames, aborts and line noise.
// A bit-level decoder kept in the bench predicts every result beat, and the
// monitor compares each one field by field, under random gaps and stalls.
// ============================================================================

module hdlc_nrzi_frame_receiver_test;
    import hnfr_pkg::*;

    localparam int FRAME_BYTES  = 512;
    localparam int ITEM_TARGET  = 1500;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 3000000;

    typedef struct packed {
        logic               op;
        logic               sym;
        logic [IDX_W-1:0]   idx;
    } t_line_beat;

    typedef struct packed {
        logic                   kind;
        logic [LEN_W-1:0]       len;
        logic [7:0]             data;
        logic [FLAG_W-1:0]      flags;
        logic [LONGEST_W-1:0]   longest;
    } t_reply;

    typedef logic [7:0] t_octet_q[$];

    // DUT connections
    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic                   opcode = OP_SYMBOL;
    logic                   line_symbol = 1'b1;
    logic [IDX_W-1:0]       read_index = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic                   result_kind;
    logic [LEN_W-1:0]       frame_length;
    logic [7:0]             read_byte;
    logic [FLAG_W-1:0]      flag_total;
    logic [LONGEST_W-1:0]   longest_fill;

    // Stimulus and scoreboard
    t_line_beat     line_beats[$];
    t_line_beat     on_offer;
    t_reply         pending_replies[$];
    int             tx_gap = 0;
    int             tx_calm = 0;
    int             rx_stall = 0;
    int             rx_calm = 0;
    logic           rx_hold = 1'b0;
    event           hold_start;
    int unsigned    mismatches = 0;
    int unsigned    cycle_count = 0;
    int unsigned    pushed = 0;
    int unsigned    symbols_fed = 0;
    int unsigned    reads_fed = 0;
    int unsigned    frames_taken = 0;

    // Line encoder state
    logic           tx_level = 1'b1;
    int             tx_ones = 0;
    bit             mix_reads = 1'b0;

    // Decoder state mirrored in the bench
    logic           prev_level = 1'b1;
    logic [7:0]     window = 8'h00;
    bit             in_frame = 1'b0;
    int             ones = 0;
    int             bit_pos = 0;
    logic [7:0]     partial = 8'h00;
    int             fill = 0;
    logic [7:0]     store[2][FRAME_BYTES];
    logic           rx_bank = 1'b0;
    logic [LEN_W-1:0] held_len = '0;
    logic [15:0]    crc_run = CRC_INIT;
    logic [7:0]     recent[2] = '{8'h00, 8'h00};
    logic [31:0]    flag_count = '0;
    int             longest = 0;

    hdlc_nrzi_frame_receiver #(
        .FRAME_BYTES    (FRAME_BYTES)
    ) u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_opcode       (opcode),
        .i_line_symbol  (line_symbol),
        .i_read_index   (read_index),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_result_kind  (result_kind),
        .o_frame_length (frame_length),
        .o_read_byte    (read_byte),
        .o_flag_total   (flag_total),
        .o_longest_fill (longest_fill)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Reflected CRC-16/X.25, one bit at a time
    function automatic logic [15:0] fcs_update(logic [15:0] c, logic [7:0] v);
        logic fb;
        for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ v[i];
            c  = c >> 1;
            if (fb) c = c ^ CRC_POLY;
        end
        return c;
    endfunction

    task automatic restart_frame();
        fill    = 0;
        bit_pos = 0;
        partial = 8'h00;
        ones    = 0;
        crc_run = CRC_INIT;
        recent  = '{8'h00, 8'h00};
    endtask

    // Pack one data bit; the CRC trails the store by two bytes (the FCS)
    task automatic shift_in(input logic b);
        partial[bit_pos] = b;
        bit_pos++;
        if (bit_pos == 8) begin
            if (fill < FRAME_BYTES) begin
                store[rx_bank][fill] = partial;
                if (fill >= 2) crc_run = fcs_update(crc_run, recent[1]);
                recent[1] = recent[0];
                recent[0] = partial;
                fill++;
            end
            if (fill > longest) longest = fill;
            partial = 8'h00;
            bit_pos = 0;
        end
    endtask

    task automatic push_reply(input logic kind, input logic [7:0] data);
        t_reply r;
        r.kind    = kind;
        r.len     = held_len;
        r.data    = data;
        r.flags   = flag_count;
        r.longest = longest[LONGEST_W-1:0];
        pending_replies.push_back(r);
    endtask

    // Advance the decoder by one accepted input beat
    task automatic decode_beat(input t_line_beat it);
        logic dbit;
        if (it.op == OP_READ) begin
            reads_fed++;
            if (it.idx < held_len) push_reply(RES_READ, store[rx_bank ^ 1'b1][it.idx]);
            else push_reply(RES_READ, 8'h00);
            return;
        end
        symbols_fed++;
        dbit       = (it.sym == prev_level);
        prev_level = it.sym;
        window     = {window[6:0], dbit};
        if (window == FLAG_PATTERN) begin
            flag_count++;
            if (in_frame && fill >= MIN_FRAME
                    && (crc_run ^ CRC_XOROUT) == {recent[0], recent[1]}) begin
                held_len = LEN_W'(fill - 2);
                rx_bank  = ~rx_bank;
                frames_taken++;
                push_reply(RES_ACCEPT, 8'h00);
            end
            in_frame = 1'b1;
            restart_frame();
            return;
        end
        if (!in_frame) return;
        if (dbit) begin
            ones++;
            if (ones >= ABORT_RUN) begin
                in_frame = 1'b0;
                ones     = 0;
                return;
            end
            shift_in(1'b1);
        end else begin
            // zero after five ones was stuffed by the sender
            if (ones == STUFF_RUN) begin
                ones = 0;
                return;
            end
            ones = 0;
            shift_in(1'b0);
        end
    endtask

    // ------------------------------------------------------------------------
    // Idle pattern shared by both sides: mostly short, a few long, and
    // occasional calm stretches with no idling at all
    // ------------------------------------------------------------------------
    function automatic int pick_idle(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r == 0) begin
            calm = $urandom_range(40, 200);
            return 0;
        end
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 30);
    endfunction

    // ------------------------------------------------------------------------
    // Driver: offers queued beats, predicts each one as it is taken
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : sender
        logic offer;
        offer = in_valid;
        if (!rst_n) begin
            offer = 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                decode_beat(on_offer);
                offer = 1'b0;
            end
            if (!offer) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (line_beats.size() > 0) begin
                    on_offer     = line_beats.pop_front();
                    opcode      <= on_offer.op;
                    line_symbol <= on_offer.sym;
                    read_index  <= on_offer.idx;
                    offer        = 1'b1;
                    tx_gap       = pick_idle(tx_calm);
                end
            end
        end
        in_valid <= offer;
    end

    // ------------------------------------------------------------------------
    // Monitor: checks each result beat against the oldest prediction
    // ------------------------------------------------------------------------
    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk) begin : receiver
        t_reply want;
        logic take;
        take = 1'b0;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (pending_replies.size() == 0) begin
                    $error("result beat with nothing expected: kind %0d, length %0d",
                           result_kind, frame_length);
                    mismatches++;
                end else begin
                    want = pending_replies.pop_front();
                    check_field("result_kind", 32'(want.kind), 32'(result_kind));
                    check_field("frame_length", 32'(want.len), 32'(frame_length));
                    check_field("read_byte", 32'(want.data), 32'(read_byte));
                    check_field("flag_total", want.flags, flag_total);
                    check_field("longest_fill", 32'(want.longest), 32'(longest_fill));
                end
                rx_stall = pick_idle(rx_calm);
            end
            if (rx_hold) begin
                take = 1'b0;
            end else if (rx_stall > 0) begin
                rx_stall--;
                take = 1'b0;
            end else begin
                take = 1'b1;
            end
        end
        out_ready <= take;
    end

    // Long receiver hold-off, counted here while the sender keeps going
    initial begin : hold_off
        forever begin
            @(hold_start);
            @(posedge clk);
            rx_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            rx_hold <= 1'b0;
        end
    end

    // Run limit
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL hdlc_nrzi_frame_receiver");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Line encoding helpers
    // ------------------------------------------------------------------------
    task automatic push_beat(input logic op, input logic sym, input int idx);
        t_line_beat b;
        b.op  = op;
        b.sym = sym;
        b.idx = IDX_W'(idx);
        line_beats.push_back(b);
        pushed++;
    endtask

    function automatic int pick_index();
        if ($urandom_range(0, 3) == 0) return $urandom_range(0, 511);
        return $urandom_range(0, 24);
    endfunction

    task automatic send_read(input int idx);
        push_beat(OP_READ, 1'($urandom_range(0, 1)), idx);
    endtask

    task automatic send_level(input logic lvl);
        if (mix_reads && $urandom_range(0, 15) == 0) send_read(pick_index());
        push_beat(OP_SYMBOL, lvl, $urandom_range(0, 511));
        tx_level = lvl;
    endtask

    // NRZI: a one keeps the level, a zero toggles it
    task automatic send_bit(input logic b);
        send_level(b ? tx_level : ~tx_level);
    endtask

    task automatic send_flag();
        for (int i = 0; i < 8; i++) send_bit(FLAG_PATTERN[i]);
        tx_ones = 0;
    endtask

    // Second flag sharing the closing zero of the one just sent
    task automatic send_shared_flag();
        repeat (6) send_bit(1'b1);
        send_bit(1'b0);
        tx_ones = 0;
    endtask

    task automatic send_octet(input logic [7:0] v);
        for (int i = 0; i < 8; i++) begin
            send_bit(v[i]);
            tx_ones = v[i] ? tx_ones + 1 : 0;
            if (tx_ones == 5) begin
                send_bit(1'b0);
                tx_ones = 0;
            end
        end
    endtask

    task automatic send_noise(input int n);
        repeat (n) send_level(1'($urandom_range(0, 1)));
        tx_ones = 0;
    endtask

    function automatic t_octet_q random_body(int n);
        t_octet_q q;
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 15) q.push_back(8'hFF);
            else if (r < 25) q.push_back(FLAG_PATTERN);
            else q.push_back(8'($urandom_range(0, 255)));
        end
        return q;
    endfunction

    // Body, FCS, optional junk past the store, stray bits, closing flag
    task automatic send_frame(input t_octet_q body, input int junk, input bit flip,
                              input int stray);
        logic [15:0] fcs;
        int at;
        int pos;
        fcs = CRC_INIT;
        foreach (body[i]) fcs = fcs_update(fcs, body[i]);
        fcs = fcs ^ CRC_XOROUT;
        if (flip && body.size() > 0) begin
            at  = $urandom_range(0, body.size() - 1);
            pos = $urandom_range(0, 7);
            body[at][pos] = ~body[at][pos];
        end
        foreach (body[i]) send_octet(body[i]);
        send_octet(fcs[7:0]);
        send_octet(fcs[15:8]);
        repeat (junk) send_octet(8'($urandom_range(0, 255)));
        repeat (stray) begin
            send_bit(1'($urandom_range(0, 1)));
        end
        tx_ones = 0;
        send_flag();
    endtask

    // Partial frame, then seven or more ones, then ignored line noise
    task automatic send_aborted(input int n);
        repeat (n) send_octet(8'($urandom_range(0, 255)));
        repeat ($urandom_range(7, 10)) send_bit(1'b1);
        send_noise($urandom_range(0, 20));
        send_flag();
    endtask

    task automatic drain_all();
        do @(negedge clk);
        while (line_beats.size() != 0 || in_valid || pending_replies.size() != 0);
    endtask

    function automatic int body_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(2, 6);
        if (r < 97) return $urandom_range(7, 24);
        return $urandom_range(25, 64);
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        t_octet_q none;
        int pick;
        bit hold_done;
        bit pause_done;
        hold_done  = 1'b0;
        pause_done = 1'b0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reads with nothing held, idle line, flags outside a frame
        send_read(0);
        send_read(511);
        repeat (10) send_bit(1'b1);
        repeat (6) send_bit(1'b0);
        send_flag();
        send_shared_flag();
        // short frame: FCS only, then a body of one byte
        send_frame(none, 0, 1'b0, 0);
        send_frame(random_body(1), 0, 1'b0, 0);
        // smallest accepted frame, read inside and past its end
        send_frame('{8'h00, 8'hFF}, 0, 1'b0, 0);
        send_read(0);
        send_read(1);
        send_read(2);
        // stuffing-heavy body, then a bad FCS, stray bits and an abort
        send_frame('{FLAG_PATTERN, 8'hFF, 8'hFF, 8'h00, 8'hF8, 8'h1F}, 0, 1'b0, 0);
        send_frame(random_body(4), 0, 1'b1, 0);
        send_frame(random_body(4), 0, 1'b0, 3);
        send_aborted(3);
        send_read(5);
        send_read(0);
        drain_all();

        // Random part
        mix_reads = 1'b1;
        while (pushed < ITEM_TARGET) begin
            while (line_beats.size() > 256) @(negedge clk);
            if (!hold_done && pushed > 900) begin
                // let the backlog go out so the reads land inside the hold
                while (line_beats.size() != 0) @(negedge clk);
                -> hold_start;
                repeat (48) send_read(pick_index());
                hold_done = 1'b1;
            end
            if (!pause_done && pushed > 1200) begin
                drain_all();
                pause_done = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 66) begin
                send_frame(random_body(body_size()), 0, 1'b0, 0);
            end else if (pick < 76) begin
                send_frame(random_body(body_size()), 0, 1'b1, 0);
            end else if (pick < 82) begin
                send_frame(random_body(body_size()), 0, 1'b0, $urandom_range(1, 7));
            end else if (pick < 88) begin
                send_frame(random_body($urandom_range(0, 1)), 0, 1'b0, 0);
            end else if (pick < 94) begin
                send_aborted($urandom_range(0, 6));
            end else begin
                send_noise($urandom_range(5, 40));
                send_flag();
            end
            if ($urandom_range(0, 3) == 0) begin
                if ($urandom_range(0, 1) == 0) send_shared_flag();
                else send_flag();
            end
        end

        drain_all();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Covered %0d line symbols and %0d reads; %0d frames passed the FCS check.",
                 symbols_fed, reads_fed, frames_taken);
        $display("Flags seen %0d, longest fill %0d bytes, last held frame %0d bytes.",
                 flag_count, longest, held_len);
        if (mismatches == 0) begin
            $display("PASS hdlc_nrzi_frame_receiver");
        end else begin
            $display("FAIL hdlc_nrzi_frame_receiver");
        end
        $finish;
    end

endmodule

>>> sim.f
design/hnfr_pkg.sv
design/hnfr_front.sv
design/hnfr_queue.sv
design/hnfr_back.sv
design/hdlc_nrzi_frame_receiver.sv
tb/hdlc_nrzi_frame_receiver_test.sv
